@@ hw/rtl/iss_pkg.sv @@
package iss_pkg;

    // Storage shape of the sequence.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths on the ports.
    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int READ_W   = 32;
    localparam int STATUS_W = 2;

    // Width used when comparing a position against the element count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_ERASE      = 3'd5,
        MODE_READ       = 3'd6,
        MODE_NONE       = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2
    } cell_op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t         op;
        logic [CMP_W-1:0] pos;
    } cell_cmd_t;

endpackage

@@ hw/rtl/iss_cell.sv @@
// One slot of the sequence. On an insert, slots above the gap take their
// left neighbor and the slot at the gap loads the new value; on an erase,
// slots at and above the gap take their right neighbor.
module iss_cell
(
    input  logic                             clk,
    input  logic                             en,
    input  iss_pkg::cell_cmd_t               cmd,
    input  logic [iss_pkg::IDX_W-1:0]        slot,
    input  logic [iss_pkg::DATA_WIDTH-1:0]   new_data,
    input  logic [iss_pkg::DATA_WIDTH-1:0]   left_data,
    input  logic [iss_pkg::DATA_WIDTH-1:0]   right_data,
    output logic [iss_pkg::DATA_WIDTH-1:0]   data
);

    logic [iss_pkg::DATA_WIDTH-1:0] data_reg;
    logic [iss_pkg::DATA_WIDTH-1:0] data_next;
    logic [iss_pkg::CMP_W-1:0]      slot_wide;

    assign slot_wide = iss_pkg::CMP_W'(slot);

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            iss_pkg::OP_INSERT:
            begin
                if (slot_wide > cmd.pos)
                begin
                    data_next = left_data;
                end
                else if (slot_wide == cmd.pos)
                begin
                    data_next = new_data;
                end
            end
            iss_pkg::OP_ERASE:
            begin
                if (slot_wide >= cmd.pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/iss_ctrl.sv @@
// Decodes one operation against the current count: the command for the
// cell row, the new count and the status of the beat.
module iss_ctrl
(
    input  logic [iss_pkg::MODE_W-1:0]   mode,
    input  logic [iss_pkg::POS_W-1:0]    position,
    input  logic [iss_pkg::CNT_W-1:0]    count,
    output iss_pkg::cell_cmd_t           cmd,
    output logic [iss_pkg::CNT_W-1:0]    count_next,
    output iss_pkg::status_t             status,
    output logic                         read_hit
);

    logic                      full;
    logic                      empty;
    logic [iss_pkg::CMP_W-1:0] pos_w;
    logic [iss_pkg::CMP_W-1:0] cnt_w;
    logic [iss_pkg::CNT_W-1:0] cnt_inc;
    logic [iss_pkg::CNT_W-1:0] cnt_dec;

    assign full    = (count == iss_pkg::CNT_W'(iss_pkg::CAPACITY));
    assign empty   = (count == '0);
    assign pos_w   = iss_pkg::CMP_W'(position);
    assign cnt_w   = iss_pkg::CMP_W'(count);
    assign cnt_inc = count + iss_pkg::CNT_W'(1);
    assign cnt_dec = count - iss_pkg::CNT_W'(1);

    always_comb
    begin
        cmd.op     = iss_pkg::OP_HOLD;
        cmd.pos    = '0;
        count_next = count;
        status     = iss_pkg::STATUS_DONE;
        read_hit   = 1'b0;
        unique case (iss_pkg::mode_t'(mode))
            iss_pkg::MODE_PUSH_FRONT,
            iss_pkg::MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    status = iss_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.op     = iss_pkg::OP_INSERT;
                    cmd.pos    = (iss_pkg::mode_t'(mode) == iss_pkg::MODE_PUSH_FRONT)
                                 ? '0 : cnt_w;
                    count_next = cnt_inc;
                end
            end
            iss_pkg::MODE_POP_FRONT,
            iss_pkg::MODE_POP_BACK:
            begin
                if (empty)
                begin
                    status = iss_pkg::STATUS_EMPTY;
                end
                else
                begin
                    cmd.op     = iss_pkg::OP_ERASE;
                    cmd.pos    = (iss_pkg::mode_t'(mode) == iss_pkg::MODE_POP_FRONT)
                                 ? '0 : iss_pkg::CMP_W'(cnt_dec);
                    count_next = cnt_dec;
                end
            end
            iss_pkg::MODE_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    status = iss_pkg::STATUS_RANGE;
                end
                else if (full)
                begin
                    status = iss_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.op     = iss_pkg::OP_INSERT;
                    cmd.pos    = pos_w;
                    count_next = cnt_inc;
                end
            end
            iss_pkg::MODE_ERASE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status = iss_pkg::STATUS_RANGE;
                end
                else
                begin
                    cmd.op     = iss_pkg::OP_ERASE;
                    cmd.pos    = pos_w;
                    count_next = cnt_dec;
                end
            end
            iss_pkg::MODE_READ:
            begin
                if (pos_w >= cnt_w)
                begin
                    status = iss_pkg::STATUS_RANGE;
                end
                else
                begin
                    read_hit = 1'b1;
                end
            end
            default:
            begin
                status = iss_pkg::STATUS_DONE;
            end
        endcase
    end

endmodule

@@ hw/rtl/indexed_sequence_store_core.sv @@
// Indexed sequence store: an ordered list of up to CAPACITY words with
// push and pop at either end, insert and erase at a position, and reads.
// Operations arrive as beats on the s_axis channel (the mode in tuser, the
// position and value in tdata). Every accepted beat produces exactly one
// result beat on the m_axis channel carrying the count after the
// operation, the word read (zero unless a read succeeded) and a status code.
// The result is registered and presented in the cycle after the input
// beat is accepted. Throughput is one operation per cycle while m_axis
// is not stalled, since the row of cells shifts the list by one slot at once.
// A new beat is accepted whenever the output register is empty or its
// current result is being taken, so a stall on m_axis holds one result and
// then stops s_axis until the receiver takes it.
// Reset empties the list and drops any pending result; the data words in
// the cells are not cleared, and no slot is read before it has been written.
module indexed_sequence_store_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: position[4:0], value[36:5], zero fill to 40 bits.
    input  logic [39:0] s_axis_tdata,
    // Fields from bit 0: mode[2:0].
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: count[4:0], read_value[36:5], zero fill to 40 bits.
    output logic [39:0] m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]  m_axis_tuser
);

    localparam int N = iss_pkg::CAPACITY;
    localparam int W = iss_pkg::DATA_WIDTH;

    logic                             accept;
    logic [iss_pkg::POS_W-1:0]        in_position;
    logic [iss_pkg::VALUE_W-1:0]      in_value;
    logic [W-1:0]                     in_data;

    iss_pkg::cell_cmd_t               cmd;
    logic [iss_pkg::CNT_W-1:0]        count_next;
    iss_pkg::status_t                 status;
    logic                             read_hit;

    logic [W-1:0]                     cell_data [N];
    logic [W-1:0]                     read_word;

    logic [iss_pkg::CNT_W-1:0]        count_reg;
    logic                             out_valid_reg;
    logic [iss_pkg::COUNT_W-1:0]      out_count_reg;
    logic [iss_pkg::READ_W-1:0]       out_read_reg;
    iss_pkg::status_t                 out_status_reg;

    assign in_position = s_axis_tdata[4:0];
    assign in_value    = s_axis_tdata[36:5];
    assign in_data     = W'(in_value);

    // The single output register frees up as soon as its beat is taken.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    iss_ctrl u_ctrl
    (
        .mode       (s_axis_tuser),
        .position   (in_position),
        .count      (count_reg),
        .cmd        (cmd),
        .count_next (count_next),
        .status     (status),
        .read_hit   (read_hit)
    );

    // Row of cells; each end ties its missing neighbor to a harmless value.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [W-1:0] left_data;
        logic [W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = in_data;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        iss_cell u_cell
        (
            .clk        (clk),
            .en         (accept),
            .cmd        (cmd),
            .slot       (iss_pkg::IDX_W'(i)),
            .new_data   (in_data),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    // Reads see the list as it stands before this beat.
    assign read_word = cell_data[iss_pkg::IDX_W'(in_position)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_count_reg  <= iss_pkg::COUNT_W'(count_next);
            out_read_reg   <= read_hit ? iss_pkg::READ_W'(read_word) : '0;
            out_status_reg <= status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_read_reg, out_count_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule
